### rtl/core/srvf_pkg.sv
// Shared types and constants for the sonar range and velocity filter.
// Used by srvf_div and sonar_range_velocity_filter; depends on nothing.
package srvf_pkg;

  // Configuration register map
  typedef enum logic [1:0] {
    REG_MIN_DIST  = 2'd0,
    REG_MAX_DIST  = 2'd1,
    REG_LPF_GAIN  = 2'd2,
    REG_VEL_LIMIT = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_GATE,
    S_MUL_NUM,
    S_MUL_LIM,
    S_CHECK,
    S_DIV,
    S_BLEND_OLD,
    S_BLEND_NEW,
    S_BLEND_SUM,
    S_DONE
  } seq_state_t;

  localparam int DIST_W   = 16;
  localparam int TIME_W   = 32;
  localparam int GAIN_W   = 9;
  localparam int VEL_W    = 25;
  localparam int NUM_W    = 36;   // |delta| * 1e6 fits in 36 bits
  localparam int OPB_W    = 17;   // narrow multiplier operand, signed
  localparam int BLEND_SH = 8;    // gain is in 1/256 units

  localparam logic [19:0]       MICRO_PER_S   = 20'd1000000;
  localparam logic [GAIN_W-1:0] GAIN_ONE      = 9'd256;
  localparam logic [DIST_W-1:0] RST_MIN_DIST  = 16'd20;
  localparam logic [DIST_W-1:0] RST_MAX_DIST  = 16'd765;
  localparam logic [GAIN_W-1:0] RST_LPF_GAIN  = 9'd102;
  localparam logic [DIST_W-1:0] RST_VEL_LIMIT = 16'd2000;
  localparam logic [DIST_W-1:0] RST_PREV_DIST = 16'd20;

endpackage

### rtl/core/sonar_range_velocity_filter.sv
// Sonar range gate with smoothed velocity estimate: one result per reading.
// An out-of-window, first or zero-interval reading goes straight to the result; one over
// the speed limit blends a zero raw velocity; any other is divided by the serial divider
// (one quotient bit a cycle) and blended on the shared multiplier (33x17 at default).
// One reading in flight; a new request is taken only once the last result is loaded.
// Reset (rst, synchronous) loads register defaults and clears the filter history.
module sonar_range_velocity_filter
  import srvf_pkg::*;
#(
  parameter int VELOCITY_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // reading in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [7:0] range_high_byte, [15:8] range_low_byte,
                                      // [47:16] timestamp_us
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] distance_out_cm, [40:16] velocity_q8,
                                      // [47:41] zero
  output logic        m_axis_tuser    // [0] healthy
);

  // Width plan: the quotient is bounded by limit * 2^F, so 16 + F bits hold it.
  localparam int QW  = DIST_W + VELOCITY_FRAC_BITS;
  localparam int RW  = QW + 1;                 // signed raw velocity
  localparam int AW  = (RW > TIME_W + 1) ? RW : TIME_W + 1;
  localparam int PW  = AW + OPB_W;             // product width
  localparam int SW  = PW + 1;                 // blend sum width

  // Configuration registers
  logic [DIST_W-1:0] min_distance_cm;
  logic [DIST_W-1:0] max_distance_cm;
  logic [GAIN_W-1:0] lpf_gain;
  logic [DIST_W-1:0] velocity_limit_cm_s;

  // Filter history
  logic [DIST_W-1:0]    prev_distance;
  logic signed [VEL_W-1:0] smoothed_velocity;
  logic                 was_healthy;
  logic [TIME_W-1:0]    prev_time;

  // Per-reading working registers
  seq_state_t        state, state_next;
  logic [DIST_W-1:0] dist_r;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] dt_r;
  logic [DIST_W-1:0] mag_r;
  logic              neg_r;
  logic [NUM_W-1:0]  num_r;
  logic signed [RW-1:0] raw_r;
  logic signed [PW-1:0] acc;

  // Shared multiplier: operands chosen by the sequencer, product registered
  logic signed [AW-1:0]    mul_a;
  logic signed [OPB_W-1:0] mul_b;
  logic signed [PW-1:0]    prod;

  // Output register
  logic [DIST_W-1:0] out_dist;
  logic [VEL_W-1:0]  out_vel;
  logic              out_healthy;
  logic              out_valid;
  logic              slot_free;

  // Combinational helpers
  logic [DIST_W:0]   delta;
  logic              in_window;
  logic [TIME_W-1:0] dt;
  logic [GAIN_W-1:0] gain_eff;
  logic [GAIN_W-1:0] gain_old;
  logic              over_limit;
  logic              div_start;
  logic              div_done;
  logic [QW-1:0]     quot;
  logic signed [SW-1:0] blend_sum;
  logic signed [SW-1:0] blend_sh;
  logic              sat_hi;
  logic              sat_lo;
  logic signed [VEL_W-1:0] vel_new;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign slot_free     = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_vel, out_dist};
  assign m_axis_tuser  = out_healthy;

  // Window test and interval use the stored reading against the history
  assign in_window = (dist_r > min_distance_cm) && (dist_r < max_distance_cm);
  assign dt        = time_r - prev_time;
  assign delta     = {1'b0, dist_r} - {1'b0, prev_distance};
  assign gain_eff  = (lpf_gain > GAIN_ONE) ? GAIN_ONE : lpf_gain;
  assign gain_old  = GAIN_ONE - gain_eff;

  // prod holds limit * dt when the sequencer sits in S_CHECK
  assign over_limit = {12'd0, num_r} > prod[TIME_W+DIST_W-1:0];

  // Blend: floor shift by 8, then clamp to the 25 bit signed range
  assign blend_sum = SW'(acc) + SW'(prod);
  assign blend_sh  = blend_sum >>> BLEND_SH;
  assign sat_hi    = !blend_sh[SW-1] && (|blend_sh[SW-2:VEL_W-1]);
  assign sat_lo    = blend_sh[SW-1] && !(&blend_sh[SW-2:VEL_W-1]);
  always_comb begin
    if (sat_hi) begin
      vel_new = {1'b0, {(VEL_W-1){1'b1}}};
    end else if (sat_lo) begin
      vel_new = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      vel_new = blend_sh[VEL_W-1:0];
    end
  end

  srvf_div #(
    .QW(QW)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend_hi (TIME_W'(num_r[NUM_W-1:DIST_W])),
    .dividend_lo ({num_r[DIST_W-1:0], {VELOCITY_FRAC_BITS{1'b0}}}),
    .divisor     (dt_r),
    .done        (div_done),
    .quotient    (quot)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance_cm     <= RST_MIN_DIST;
      max_distance_cm     <= RST_MAX_DIST;
      lpf_gain            <= RST_LPF_GAIN;
      velocity_limit_cm_s <= RST_VEL_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DIST:  min_distance_cm     <= cfg_data;
        REG_MAX_DIST:  max_distance_cm     <= cfg_data;
        REG_LPF_GAIN:  lpf_gain            <= cfg_data[GAIN_W-1:0];
        REG_VEL_LIMIT: velocity_limit_cm_s <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operand selection
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_GATE;
        end
      end
      S_GATE: begin
        // drop to a zero velocity unless this reading is in window and follows a healthy one in time
        if (in_window && was_healthy && (dt != '0)) begin
          state_next = S_MUL_NUM;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MUL_NUM: begin
        mul_a      = AW'(MICRO_PER_S);
        mul_b      = OPB_W'(mag_r);
        state_next = S_MUL_LIM;
      end
      S_MUL_LIM: begin
        mul_a      = AW'(dt_r);
        mul_b      = OPB_W'(velocity_limit_cm_s);
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (over_limit) begin
          state_next = S_BLEND_OLD;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_BLEND_OLD;
        end
      end
      S_BLEND_OLD: begin
        mul_a      = AW'(smoothed_velocity);
        mul_b      = OPB_W'(gain_old);
        state_next = S_BLEND_NEW;
      end
      S_BLEND_NEW: begin
        mul_a      = AW'(raw_r);
        mul_b      = OPB_W'(gain_eff);
        state_next = S_BLEND_SUM;
      end
      S_BLEND_SUM: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          dist_r <= {s_axis_tdata[7:0], s_axis_tdata[15:8]};
          time_r <= s_axis_tdata[47:16];
        end
      end
      S_GATE: begin
        dt_r  <= dt;
        neg_r <= delta[DIST_W];
        mag_r <= DIST_W'(delta[DIST_W] ? (~delta + 1'b1) : delta);
      end
      S_MUL_LIM: begin
        num_r <= prod[NUM_W-1:0];
      end
      S_CHECK: begin
        raw_r <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          raw_r <= neg_r ? -RW'(quot) : RW'(quot);
        end
      end
      S_BLEND_NEW: begin
        acc <= prod;
      end
      default: ;
    endcase
  end

  // Filter history: commit on gate, velocity on blend
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_distance     <= RST_PREV_DIST;
      smoothed_velocity <= '0;
      was_healthy       <= 1'b0;
      prev_time         <= '0;
    end else begin
      case (state)
        S_GATE: begin
          prev_time   <= time_r;
          was_healthy <= in_window;
          if (in_window) begin
            prev_distance <= dist_r;
          end
          if (!(in_window && was_healthy && (dt != '0))) begin
            smoothed_velocity <= '0;
          end
        end
        S_BLEND_SUM: begin
          smoothed_velocity <= vel_new;
        end
        default: ;
      endcase
    end
  end

  // Output register: load when the slot frees, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      out_dist    <= prev_distance;
      out_vel     <= smoothed_velocity;
      out_healthy <= was_healthy;
    end
  end

endmodule

### rtl/core/srvf_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses srvf_pkg for the timestamp width; caller guarantees the quotient fits in QW bits.
module srvf_div
  import srvf_pkg::*;
#(
  parameter int QW = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend_hi,  // upper dividend bits, below divisor
  input  logic [QW-1:0]     dividend_lo,  // lower dividend bits, shifted in one a cycle
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [QW-1:0]     quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [TIME_W-1:0] rem;
  logic [QW-1:0]     qreg;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;

  assign trial    = {rem, qreg[QW-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = trial >= {1'b0, divisor};
  assign quotient = qreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend_hi;
      qreg <= dividend_lo;
    end else if (busy) begin
      // keep the partial remainder below the divisor
      rem  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      qreg <= {qreg[QW-2:0], ge};
    end
  end

endmodule

### tb/tb.sv
// Self-checking bench for sonar_range_velocity_filter: a directed table of readings and
// register writes, then randomised reading streams under several register settings.
// Depends on srvf_pkg and the filter RTL; results are scored by a predictor or typed rows.
`timescale 1ns / 100ps

module tb;
  import srvf_pkg::*;

  localparam int     VEL_FRAC           = 8;
  localparam int     HALF_PERIOD        = 6;
  localparam int     CYCLE_LIMIT        = 1000000;
  localparam int     PHASES             = 8;
  localparam int     READINGS_PER_PHASE = 100;
  localparam longint VEL_TOP            = 64'sd16777215;
  localparam longint VEL_BOTTOM         = -64'sd16777216;

  // One result as the filter reports it; vel holds the raw 25 bit pattern
  typedef struct packed {
    logic [15:0] cm;
    logic [24:0] vel;
    logic        ok;
  } range_result_t;

  // Directed table row: either a register write or a reading, with an optional
  // hand-written result where it is obvious
  typedef struct {
    bit            is_write;
    cfg_reg_t      sel;
    logic [15:0]   value;
    logic [15:0]   cm;
    logic [31:0]   ts;
    bit            fixed;
    range_result_t want;
  } bench_row_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = 2'd0;
  logic [15:0] cfg_data      = 16'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = 48'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Predictor copy of the registers and of the filter history
  logic [15:0] win_lo;
  logic [15:0] win_hi;
  logic [8:0]  blend_gain;
  logic [15:0] speed_limit;
  logic [15:0] last_dist;
  longint      vel_est;
  bit          track_ok;
  logic [31:0] last_ts;

  range_result_t owed_results[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            rx_left        = 0;
  bit            tx_steady      = 1'b0;
  bit            rx_steady      = 1'b0;

  sonar_range_velocity_filter #(
    .VELOCITY_FRAC_BITS(VEL_FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sonar_range_velocity_filter regression: fail");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input longint want, input longint got);
    $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    mismatch_count++;
  endtask

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 70) return int'($urandom_range(1, 3));
    if (r < 95) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 40));
  endfunction

  function automatic int sender_gap();
    if (tx_steady || $urandom_range(0, 1) == 0) return 0;
    return pause_len();
  endfunction

  // Move a distance into the open window; with no room left any value will do
  function automatic int fit_window(int cm);
    int lo;
    int hi;
    lo = int'(win_lo);
    hi = int'(win_hi);
    if (hi - lo <= 1) return int'($urandom_range(0, 65535));
    if (cm <= lo || cm >= hi) return lo + 1 + int'($urandom_range(0, hi - lo - 2));
    return cm;
  endfunction

  // Advance the predictor by one reading and return the result it owes
  function automatic range_result_t predict_range(logic [15:0] d, logic [31:0] ts);
    logic [31:0]     dt;
    longint          delta;
    longint          raw;
    longint          g;
    longint          blended;
    longint unsigned mag;
    longint unsigned num;
    longint unsigned quot;
    range_result_t   r;
    dt = ts - last_ts;
    if (d > win_lo && d < win_hi) begin
      if (track_ok && dt != 32'd0) begin
        delta = longint'({48'd0, d}) - longint'({48'd0, last_dist});
        mag   = (delta < 0) ? -delta : delta;
        num   = mag * 64'd1000000;
        g     = (blend_gain > GAIN_ONE) ? 64'sd256 : longint'({55'd0, blend_gain});
        raw   = 0;
        // Exact speed test: over the limit gives a raw velocity of zero
        if (num <= {48'd0, speed_limit} * {32'd0, dt}) begin
          quot = (num << VEL_FRAC) / {32'd0, dt};
          raw  = (delta < 0) ? -longint'(quot) : longint'(quot);
        end
        // Floor of the weighted sum over 256, then clamp to 25 bits
        blended = ((64'sd256 - g) * vel_est + g * raw) >>> 8;
        if (blended > VEL_TOP) blended = VEL_TOP;
        else if (blended < VEL_BOTTOM) blended = VEL_BOTTOM;
        vel_est = blended;
      end else begin
        vel_est = 0;
      end
      last_dist = d;
      track_ok  = 1'b1;
    end else begin
      vel_est  = 0;
      track_ok = 1'b0;
    end
    last_ts = ts;
    r.cm    = last_dist;
    r.vel   = vel_est[24:0];
    r.ok    = track_ok;
    return r;
  endfunction

  function automatic bench_row_t item_row(logic [15:0] d, logic [31:0] ts);
    bench_row_t r;
    r.is_write = 1'b0;
    r.sel      = REG_MIN_DIST;
    r.value    = 16'd0;
    r.cm       = d;
    r.ts       = ts;
    r.fixed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  // Reading whose result is written out by hand; all of these carry zero velocity
  function automatic bench_row_t typed_row(logic [15:0] d, logic [31:0] ts,
                                           logic [15:0] xd, logic xok);
    bench_row_t r;
    r            = item_row(d, ts);
    r.fixed      = 1'b1;
    r.want.cm    = xd;
    r.want.vel   = 25'd0;
    r.want.ok    = xok;
    return r;
  endfunction

  function automatic bench_row_t cfg_row(cfg_reg_t sel, logic [15:0] value);
    bench_row_t r;
    r          = item_row(16'd0, 32'd0);
    r.is_write = 1'b1;
    r.sel      = sel;
    r.value    = value;
    return r;
  endfunction

  // Hold the write request until taken, then update the predictor's registers.
  // The caller drops cfg_valid after the last write of a run.
  task automatic write_register(input cfg_reg_t sel, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      REG_MIN_DIST:  win_lo      = value;
      REG_MAX_DIST:  win_hi      = value;
      REG_LPF_GAIN:  blend_gain  = value[8:0];
      REG_VEL_LIMIT: speed_limit = value;
      default: ;
    endcase
  endtask

  // Drop the reading request and wait until every owed result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  task automatic write_settings(input logic [15:0] lo, input logic [15:0] hi,
                                input logic [8:0] gain, input logic [15:0] limit);
    drain_results();
    write_register(REG_MIN_DIST, lo);
    write_register(REG_MAX_DIST, hi);
    write_register(REG_LPF_GAIN, {7'd0, gain});
    write_register(REG_VEL_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Offer one reading after an optional gap. tvalid is left high on return so a
  // back-to-back request never lowers and raises it in one step.
  task automatic send_reading(input logic [15:0] d, input logic [31:0] ts, input int gap,
                              input bit fixed, input range_result_t want);
    range_result_t r;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ts, d[7:0], d[15:8]};
    do @(posedge clk); while (!s_axis_tready);
    r = predict_range(d, ts);
    owed_results.push_back(fixed ? want : r);
  endtask

  // Result side: score each accepted result, then pick the next ready level
  always @(posedge clk) begin : result_side
    range_result_t seen;
    range_result_t owed;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.cm   = m_axis_tdata[15:0];
      seen.vel  = m_axis_tdata[40:16];
      seen.ok   = m_axis_tuser;
      if (m_axis_tdata[47:41] != 7'd0)
        note_mismatch("tdata padding", 0, 64'(m_axis_tdata[47:41]));
      if (owed_results.size() == 0) begin
        note_mismatch("result with nothing owed", 0, 1);
      end else begin
        owed = owed_results.pop_front();
        if (seen.cm != owed.cm)
          note_mismatch("distance_out_cm", 64'(owed.cm), 64'(seen.cm));
        if (seen.vel != owed.vel)
          note_mismatch("velocity_q8", 64'($signed(owed.vel)), 64'($signed(seen.vel)));
        if (seen.ok != owed.ok)
          note_mismatch("healthy", 64'(owed.ok), 64'(seen.ok));
      end
    end
    // Stall at random, except during steady stretches
    if (rx_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_left       <= rx_left - 1;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_left       <= pause_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    bench_row_t  plan[$];
    int          cur_cm;
    int          lo_cm;
    int          hi_cm;
    int          kind;
    logic [15:0] d;
    logic [31:0] now_us;

    // Predictor starts from the reset state
    win_lo      = RST_MIN_DIST;
    win_hi      = RST_MAX_DIST;
    blend_gain  = RST_LPF_GAIN;
    speed_limit = RST_VEL_LIMIT;
    last_dist   = RST_PREV_DIST;
    vel_est     = 0;
    track_ok    = 1'b0;
    last_ts     = 32'd0;

    // Reset settings: window edges are exclusive, first valid reading has no velocity
    plan.push_back(typed_row(16'h0000, 32'd0,     16'd20,  1'b0));
    plan.push_back(typed_row(16'd20,   32'd100,   16'd20,  1'b0));
    plan.push_back(typed_row(16'd765,  32'd200,   16'd20,  1'b0));
    plan.push_back(typed_row(16'd21,   32'd1000,  16'd21,  1'b1));
    // Same timestamp again: zero interval forces velocity to zero
    plan.push_back(typed_row(16'd764,  32'd1000,  16'd764, 1'b1));
    // Approach, exactly at the speed limit, just over it
    plan.push_back(item_row(16'd700,   32'd51000));
    plan.push_back(item_row(16'd720,   32'd61000));
    plan.push_back(item_row(16'd741,   32'd71000));
    // All ones reading is out of window; distance is held
    plan.push_back(typed_row(16'hFFFF, 32'hFFFF_FFFF, 16'd741, 1'b0));
    plan.push_back(typed_row(16'h0102, 32'h0000_0010, 16'd258, 1'b1));
    plan.push_back(item_row(16'h0180,  32'h0000_2720));
    // Timestamp going backwards wraps to a huge interval, then steps forward
    plan.push_back(item_row(16'h01AA,  32'h0000_0005));
    plan.push_back(item_row(16'h01A0,  32'h0000_2000));
    // Widest window, full gain, top speed limit: largest swings up and down
    plan.push_back(cfg_row(REG_MIN_DIST,  16'd0));
    plan.push_back(cfg_row(REG_MAX_DIST,  16'hFFFF));
    plan.push_back(cfg_row(REG_LPF_GAIN,  {7'd0, GAIN_ONE}));
    plan.push_back(cfg_row(REG_VEL_LIMIT, 16'hFFFF));
    plan.push_back(item_row(16'h0001,  32'h0010_0000));
    plan.push_back(item_row(16'hFFFE,  32'h001F_4240));
    plan.push_back(item_row(16'h0001,  32'h002E_8480));
    plan.push_back(typed_row(16'h0000, 32'h002E_8490, 16'h0001, 1'b0));
    // Gain above one is clamped; zero speed limit kills every nonzero step
    plan.push_back(cfg_row(REG_LPF_GAIN,  16'h01FF));
    plan.push_back(cfg_row(REG_VEL_LIMIT, 16'd0));
    plan.push_back(typed_row(16'h8000, 32'h4000_0000, 16'h8000, 1'b1));
    plan.push_back(item_row(16'h8000,  32'h4000_0064));
    plan.push_back(item_row(16'h8001,  32'h4000_00C8));
    // Zero gain holds the old estimate
    plan.push_back(cfg_row(REG_LPF_GAIN,  16'd0));
    plan.push_back(cfg_row(REG_VEL_LIMIT, 16'd2000));
    plan.push_back(item_row(16'h8010,  32'h4000_27D8));
    // Empty windows: one apart, then inverted at the top
    plan.push_back(cfg_row(REG_MIN_DIST,  16'd100));
    plan.push_back(cfg_row(REG_MAX_DIST,  16'd101));
    plan.push_back(typed_row(16'd100,  32'hAAAA_5555, 16'h8010, 1'b0));
    plan.push_back(typed_row(16'd101,  32'h5555_AAAA, 16'h8010, 1'b0));
    plan.push_back(cfg_row(REG_MIN_DIST,  16'hFFFF));
    plan.push_back(typed_row(16'h7FFF, 32'h8000_0001, 16'h8010, 1'b0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; a run of writes only starts once the filter is idle
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (i == 0 || !plan[i-1].is_write) drain_results();
        write_register(plan[i].sel, plan[i].value);
        if (i + 1 == plan.size() || !plan[i+1].is_write) cfg_valid <= 1'b0;
      end else begin
        send_reading(plan[i].cm, plan[i].ts, sender_gap(), plan[i].fixed, plan[i].want);
      end
    end

    // Randomised streams, one register setting per phase
    now_us = 32'h0100_0000;
    cur_cm = 400;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_settings(RST_MIN_DIST, RST_MAX_DIST, RST_LPF_GAIN, RST_VEL_LIMIT);
        1: write_settings(16'd0, 16'hFFFF, GAIN_ONE, 16'hFFFF);
        2: write_settings(16'd50, 16'd3000, 9'd0, 16'd500);
        3: write_settings(16'd0, 16'd400, 9'd1, 16'd100);
        6: write_settings(16'd1000, 16'd1003, 9'd128, 16'd0);
        default: write_settings(16'($urandom_range(0, 300)), 16'($urandom_range(400, 65535)),
                                9'($urandom_range(0, 511)), 16'($urandom_range(200, 8000)));
      endcase
      tx_steady = (p % 3 == 2);
      rx_steady = (p % 4 == 1);
      lo_cm     = int'(win_lo);
      hi_cm     = int'(win_hi);
      cur_cm    = fit_window(cur_cm);
      for (int n = 0; n < READINGS_PER_PHASE; n++) begin
        // Halfway through, hold off until the filter has caught up
        if (n == READINGS_PER_PHASE / 2) drain_results();
        kind = int'($urandom_range(0, 99));
        if (kind < 65) begin
          // Plausible track: small step, typical sonar interval
          cur_cm = fit_window(cur_cm + int'($urandom_range(0, 80)) - 40);
          d      = 16'(cur_cm);
          now_us += 32'($urandom_range(2000, 120000));
        end else if (kind < 73) begin
          // Jump within the window, short interval: usually over the limit
          cur_cm = fit_window(int'($urandom_range(0, 65535)));
          d      = 16'(cur_cm);
          now_us += 32'($urandom_range(1, 3000));
        end else if (kind < 78) begin
          // Repeat the timestamp
          cur_cm = fit_window(cur_cm + int'($urandom_range(0, 2)) - 1);
          d      = 16'(cur_cm);
        end else if (kind < 85) begin
          // Outside the window
          if (lo_cm > 0 && $urandom_range(0, 1) == 1) d = 16'($urandom_range(0, lo_cm));
          else d = 16'($urandom_range(hi_cm, 65535));
          now_us += 32'($urandom_range(2000, 120000));
        end else if (kind < 93) begin
          // Noise on every bit
          d      = 16'($urandom_range(0, 65535));
          now_us = $urandom();
        end else begin
          // Park the timestamp just short of the wrap
          cur_cm = fit_window(cur_cm + int'($urandom_range(0, 20)) - 10);
          d      = 16'(cur_cm);
          now_us = 32'hFFFF_FFFF - 32'($urandom_range(0, 60000));
        end
        send_reading(d, now_us, sender_gap(), 1'b0, '0);
      end
    end

    // Let the last results drain, then watch for strays
    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sonar_range_velocity_filter regression: pass");
    end else begin
      $display("sonar_range_velocity_filter regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/srvf_pkg.sv
rtl/core/srvf_div.sv
rtl/core/sonar_range_velocity_filter.sv
tb/tb.sv
